[rtl/core/iiea_pkg.sv]
package iiea_pkg;

	localparam int OPCODE_W   = 2;
	localparam int POS_W      = 7;
	localparam int WORD_W     = 32;
	localparam int COUNT_W    = 7;
	localparam int STATUS_W   = 2;
	localparam int CAPACITY_D = 64;

	localparam logic [OPCODE_W-1:0] OP_READ   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SET    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_ERASE  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// broadcast to every cell, already qualified by acceptance and status
	typedef struct packed {
		logic do_set;
		logic do_ins;
		logic do_era;
	} cmd_t;

endpackage

[rtl/core/iiea_cell.sv]
module iiea_cell #(
	parameter int INDEX = 0,
	parameter int CMP_W = 7
) (
	input  logic                             clk,
	input  iiea_pkg::cmd_t                   cmd,
	input  logic [CMP_W-1:0]                 pos,
	input  logic signed [iiea_pkg::WORD_W-1:0] value_in,
	input  logic signed [iiea_pkg::WORD_W-1:0] left_word,
	input  logic signed [iiea_pkg::WORD_W-1:0] right_word,
	output logic signed [iiea_pkg::WORD_W-1:0] word,
	output logic signed [iiea_pkg::WORD_W-1:0] rd_word
);

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

	logic                              hit;
	logic                              above;
	logic signed [iiea_pkg::WORD_W-1:0] word_q;

	assign hit   = (MY_IDX == pos);
	assign above = (MY_IDX > pos);

	always_ff @(posedge clk) begin
		if (cmd.do_set && hit) begin
			word_q <= value_in;
		end else if (cmd.do_ins) begin
			if (hit) begin
				word_q <= value_in;
			end else if (above) begin
				word_q <= left_word;
			end
		end else if (cmd.do_era && (hit || above)) begin
			word_q <= right_word;
		end
	end

	assign word    = word_q;
	assign rd_word = hit ? word_q : '0;

endmodule

[rtl/core/indexed_insert_erase_array_unit.sv]
// Ordered list of up to CAPACITY signed words, one cell per entry. For every
// item (read, set, insert, erase) all cells update together, insert and
// erase moving each later entry one place along the chain. The result
// enters the output register in the cycle after acceptance, so the unit
// sustains one item per cycle; in_stall is raised only while a finished
// result waits on out_stall. Entries are not cleared at reset; only
// entries below count are ever read back.
module indexed_insert_erase_array_unit #(
	parameter int CAPACITY = iiea_pkg::CAPACITY_D
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [iiea_pkg::OPCODE_W-1:0]        opcode,
	input  logic [iiea_pkg::POS_W-1:0]           position,
	input  logic signed [iiea_pkg::WORD_W-1:0]   value_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [iiea_pkg::WORD_W-1:0]   read_value,
	output logic [iiea_pkg::COUNT_W-1:0]         count,
	output logic                                 is_empty,
	output logic [iiea_pkg::STATUS_W-1:0]        status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = iiea_pkg::POS_W;
	localparam int CW    = iiea_pkg::COUNT_W;
	localparam int CMP_W = (CNT_W > PW) ? CNT_W : PW;
	localparam int WW    = iiea_pkg::WORD_W;

	logic [CNT_W-1:0]        length_q;
	logic                    out_valid_q;
	logic signed [WW-1:0]    rd_value_q;
	logic [CW-1:0]           count_q;
	logic                    empty_q;
	logic [iiea_pkg::STATUS_W-1:0] status_q;

	logic                    accept;
	logic [CMP_W-1:0]        pos_ext;
	logic [CMP_W-1:0]        len_ext;
	logic                    in_range;
	logic                    full;
	logic [iiea_pkg::STATUS_W-1:0] st;
	logic                    ok;
	logic [CNT_W-1:0]        length_nxt;
	iiea_pkg::cmd_t          cmd;
	logic signed [WW-1:0]    words    [CAPACITY];
	logic signed [WW-1:0]    rd_words [CAPACITY];
	logic signed [WW-1:0]    rd_or;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign pos_ext  = CMP_W'(position);
	assign len_ext  = CMP_W'(length_q);
	assign in_range = pos_ext < len_ext;
	assign full     = (length_q == CNT_W'(CAPACITY));

	always_comb begin
		st = iiea_pkg::ST_OK;
		unique case (opcode)
			iiea_pkg::OP_READ, iiea_pkg::OP_SET, iiea_pkg::OP_ERASE: begin
				if (!in_range) st = iiea_pkg::ST_INDEX;
			end
			iiea_pkg::OP_INSERT: begin
				if (pos_ext > len_ext) st = iiea_pkg::ST_INDEX;
				else if (full) st = iiea_pkg::ST_FULL;
			end
			default: st = iiea_pkg::ST_OK;
		endcase
	end

	assign ok         = (st == iiea_pkg::ST_OK);
	assign cmd.do_set = accept && ok && (opcode == iiea_pkg::OP_SET);
	assign cmd.do_ins = accept && ok && (opcode == iiea_pkg::OP_INSERT);
	assign cmd.do_era = accept && ok && (opcode == iiea_pkg::OP_ERASE);

	always_comb begin
		length_nxt = length_q;
		if (cmd.do_ins) length_nxt = length_q + CNT_W'(1);
		else if (cmd.do_era) length_nxt = length_q - CNT_W'(1);
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic signed [WW-1:0] left_w;
			logic signed [WW-1:0] right_w;
			if (gi == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = words[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_w = words[gi];
			end else begin : g_mid_r
				assign right_w = words[gi+1];
			end
			iiea_cell #(
				.INDEX (gi),
				.CMP_W (CMP_W)
			) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.pos        (pos_ext),
				.value_in   (value_in),
				.left_word  (left_w),
				.right_word (right_w),
				.word       (words[gi]),
				.rd_word    (rd_words[gi])
			);
		end
	endgenerate

	// at most one cell matches, so an OR picks the addressed word
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | rd_words[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			length_q <= length_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_value_q <= (ok && (opcode == iiea_pkg::OP_READ)) ? rd_or : '0;
			count_q    <= CW'(length_nxt);
			empty_q    <= (length_nxt == '0);
			status_q   <= st;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = rd_value_q;
	assign count      = count_q;
	assign is_empty   = empty_q;
	assign status     = status_q;

`ifndef SYNTHESIS
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= CNT_W'(CAPACITY))
		else $error("length above capacity");

	a_acc_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

	a_ins_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_ins |=> (length_q == $past(length_q) + CNT_W'(1)))
		else $error("insert did not grow list");

	a_era_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_era |=> (length_q == $past(length_q) - CNT_W'(1)))
		else $error("erase did not shrink list");

	a_bad_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ok) |=> $stable(length_q))
		else $error("failed item changed length");
`endif

endmodule
